// ===== rtl/framed_command_parser_responder_defines.svh =====
// Assertion macros shared by the framed command parser/responder RTL.
// No dependencies; included by modules that carry assertions.
`ifndef FRAMED_COMMAND_PARSER_RESPONDER_DEFINES_SVH
`define FRAMED_COMMAND_PARSER_RESPONDER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FCPR_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled during reset.
`define FCPR_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== rtl/fcpr_pkg.sv =====
// Shared types and constants for the framed command parser/responder.
// No dependencies; imported by every module of the block.
package fcpr_pkg;

    localparam int unsigned BYTE_W        = 8;
    localparam int unsigned QUEUE_DEPTH_D = 4;

    localparam logic [BYTE_W-1:0] CH_U     = 8'h55;
    localparam logic [BYTE_W-1:0] CH_N     = 8'h4E;
    localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
    localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] REPLY_LEN = 8'd3;

    // header plus token, the fixed part of every frame checksum
    localparam logic [BYTE_W-1:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

    // reply byte positions
    typedef enum logic [3:0] {
        RB_U      = 4'd0,
        RB_N      = 4'd1,
        RB_E      = 4'd2,
        RB_R      = 4'd3,
        RB_LEN    = 4'd4,
        RB_COLON  = 4'd5,
        RB_CMD    = 4'd6,
        RB_STATUS = 4'd7,
        RB_CSUM   = 4'd8
    } reply_idx_t;

    typedef enum logic [2:0] {
        ST_WAIT_U  = 3'd0,
        ST_N       = 3'd1,
        ST_E       = 3'd2,
        ST_R       = 3'd3,
        ST_LEN     = 3'd4,
        ST_TOKEN   = 3'd5,
        ST_PAYLOAD = 3'd6
    } parse_state_t;

    typedef enum logic [1:0] {
        CFG_ALIVE_CMD    = 2'd0,
        CFG_ACK_CODE     = 2'd1,
        CFG_UNKNOWN_CODE = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic              push;
        logic [BYTE_W-1:0] cmd;
    } cmd_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] alive_cmd;
        logic [BYTE_W-1:0] ack_code;
        logic [BYTE_W-1:0] unknown_code;
    } cfg_regs_t;

endpackage

// ===== rtl/fcpr_front.sv =====
// Front end: frame parser that takes one received byte per cycle while the queue
// is not full and pushes the command of each frame with a good checksum. Uses fcpr_pkg.
module fcpr_front
    import fcpr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    input  queue_status_t     q_status,
    output cmd_push_t         cmd_push
);

    parse_state_t      state_reg, state_next;
    logic [BYTE_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0] csum_reg, csum_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic              first_reg, first_next;

    logic              accept;
    logic              frame_ok;
    logic [BYTE_W-1:0] count_dec;

    assign accept    = s_tvalid && s_tready;
    assign count_dec = count_reg - 8'd1;

    // next state
    always_comb begin
        logic mismatch;
        mismatch   = 1'b0;
        state_next = state_reg;
        count_next = count_reg;
        csum_next  = csum_reg;
        cmd_next   = cmd_reg;
        first_next = first_reg;
        frame_ok   = 1'b0;
        if (accept) begin
            case (state_reg)
                ST_WAIT_U: begin
                    if (s_tdata == CH_U) state_next = ST_N;
                end
                ST_N: begin
                    if (s_tdata == CH_N) state_next = ST_E;
                    else mismatch = 1'b1;
                end
                ST_E: begin
                    if (s_tdata == CH_E) state_next = ST_R;
                    else mismatch = 1'b1;
                end
                ST_R: begin
                    if (s_tdata == CH_R) state_next = ST_LEN;
                    else mismatch = 1'b1;
                end
                ST_LEN: begin
                    count_next = s_tdata;
                    state_next = ST_TOKEN;
                end
                ST_TOKEN: begin
                    if (s_tdata == CH_COLON) begin
                        csum_next  = HDR_XOR ^ count_reg;
                        first_next = 1'b1;
                        state_next = ST_PAYLOAD;
                    end else begin
                        mismatch = 1'b1;
                    end
                end
                ST_PAYLOAD: begin
                    if (first_reg) begin
                        cmd_next   = s_tdata;
                        first_next = 1'b0;
                    end
                    count_next = count_dec;
                    if (count_dec != 8'd0) begin
                        csum_next = csum_reg ^ s_tdata;
                    end else begin
                        frame_ok   = (s_tdata == csum_reg);
                        state_next = ST_WAIT_U;
                    end
                end
                default: begin
                    state_next = ST_WAIT_U;
                end
            endcase
            // a bad header or token byte may itself open the next header
            if (mismatch) state_next = (s_tdata == CH_U) ? ST_N : ST_WAIT_U;
        end
    end

    // outputs
    always_comb begin
        s_tready      = !q_status.full;
        cmd_push.push = frame_ok;
        // length one: the checksum byte doubles as the command
        cmd_push.cmd  = first_reg ? s_tdata : cmd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_WAIT_U;
            count_reg <= '0;
            csum_reg  <= '0;
            cmd_reg   <= '0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            csum_reg  <= csum_next;
            cmd_reg   <= cmd_next;
            first_reg <= first_next;
        end
    end

endmodule

// ===== rtl/fcpr_queue.sv =====
// Command queue between the parser and the reply generator.
// Uses fcpr_pkg and the assertion macros header.
`include "framed_command_parser_responder_defines.svh"

module fcpr_queue
    import fcpr_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_D
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  cmd_push_t         cmd_push,
    input  logic              pop,
    output logic [BYTE_W-1:0] pop_cmd,
    output queue_status_t     q_status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [BYTE_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    logic do_push, do_pop;

    assign do_push = cmd_push.push;
    assign do_pop  = pop;

    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);
    assign pop_cmd        = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)  rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)      count_next = count_reg + 1'b1;
        else if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= cmd_push.cmd;
    end

    `FCPR_ASSERT_IMP(a_no_push_full, aclk, aresetn, do_push, !q_status.full)
    `FCPR_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, do_pop, !q_status.empty)
    `FCPR_ASSERT_NXT(a_push_fills, aclk, aresetn, do_push && !do_pop, !q_status.empty)
    `FCPR_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_FULL)

endmodule

// ===== rtl/fcpr_back.sv =====
// Back end: takes one queued command at a time and sends its nine-byte
// reply frame, one byte per accepted output beat. Uses fcpr_pkg.
module fcpr_back
    import fcpr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_regs_t         cfg,
    input  queue_status_t     q_status,
    input  logic [BYTE_W-1:0] pop_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] tx_byte
    output logic              m_tlast    // last_byte
);

    logic              active_reg, active_next;
    reply_idx_t        idx_reg, idx_next;
    logic [BYTE_W-1:0] cmd_reg, cmd_next;
    logic [BYTE_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0] csum_reg, csum_next;

    logic              take;
    logic [BYTE_W-1:0] status_new;

    assign take       = !active_reg || (m_tready && idx_reg == RB_CSUM);
    assign status_new = (pop_cmd == cfg.alive_cmd) ? cfg.ack_code : cfg.unknown_code;

    always_comb begin
        pop         = 1'b0;
        active_next = active_reg;
        idx_next    = idx_reg;
        cmd_next    = cmd_reg;
        status_next = status_reg;
        csum_next   = csum_reg;
        if (take) begin
            if (!q_status.empty) begin
                pop         = 1'b1;
                active_next = 1'b1;
                idx_next    = RB_U;
                cmd_next    = pop_cmd;
                status_next = status_new;
                csum_next   = HDR_XOR ^ REPLY_LEN ^ pop_cmd ^ status_new;
            end else begin
                active_next = 1'b0;
            end
        end else if (m_tready) begin
            idx_next = reply_idx_t'(idx_reg + 4'd1);
        end
    end

    always_comb begin
        case (idx_reg)
            RB_U:      m_tdata = CH_U;
            RB_N:      m_tdata = CH_N;
            RB_E:      m_tdata = CH_E;
            RB_R:      m_tdata = CH_R;
            RB_LEN:    m_tdata = REPLY_LEN;
            RB_COLON:  m_tdata = CH_COLON;
            RB_CMD:    m_tdata = cmd_reg;
            RB_STATUS: m_tdata = status_reg;
            RB_CSUM:   m_tdata = csum_reg;
            default:   m_tdata = csum_reg;
        endcase
        m_tvalid = active_reg;
        m_tlast  = (idx_reg == RB_CSUM);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            idx_reg    <= RB_U;
        end else begin
            active_reg <= active_next;
            idx_reg    <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        status_reg <= status_next;
        csum_reg   <= csum_next;
    end

endmodule

// ===== rtl/framed_command_parser_responder.sv =====
// Framed command parser and responder: received bytes enter on s_ at one per
// cycle while the queue is not full and are parsed in the same cycle; a frame
// with a good checksum puts its command into a queue of QUEUE_DEPTH entries,
// and the reply side sends a nine-byte reply for each queued command, one byte
// per beat, the next reply starting right after the previous last byte. With
// the reply side idle, the queue stores the command as the checksum byte is
// taken; the reply side then pops it and registers its first byte. s_tready
// drops only while the queue is full, which happens when replies are drained
// more slowly than frames arrive. Registers are written on the cfg channel,
// always ready; they are meant to change only while no reply is pending.
// Depends on fcpr_pkg and the submodules fcpr_front, fcpr_queue, fcpr_back.
module framed_command_parser_responder
    import fcpr_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_D
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] tx_byte
    output logic              m_tlast,   // last_byte
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [BYTE_W-1:0] cfg_data
);

    cfg_regs_t         cfg_reg, cfg_next;
    cmd_push_t         cmd_push;
    queue_status_t     q_status;
    logic              pop;
    logic [BYTE_W-1:0] pop_cmd;

    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index_t'(cfg_index))
                CFG_ALIVE_CMD:    cfg_next.alive_cmd    = cfg_data;
                CFG_ACK_CODE:     cfg_next.ack_code     = cfg_data;
                CFG_UNKNOWN_CODE: cfg_next.unknown_code = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alive_cmd    <= 8'd240;
            cfg_reg.ack_code     <= 8'd13;
            cfg_reg.unknown_code <= 8'd255;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    fcpr_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_status (q_status),
        .cmd_push (cmd_push)
    );

    fcpr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd_push (cmd_push),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .q_status (q_status)
    );

    fcpr_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .pop_cmd  (pop_cmd),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for framed_command_parser_responder: frames, broken frames and noise
// in on s_, replies checked byte by byte on m_ against an in-bench frame parser.
// Depends on fcpr_pkg and the RTL of the block; reads no files.
module tb_top
    import fcpr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD     = 10;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 6;
    localparam int PHASE_ITEMS    = 40;
    localparam logic [1:0] CFG_IDX_SPARE = 2'd3;   // not a register, write is dropped

    // idle percentages per random phase: none, sender, receiver, both
    localparam int SEND_GAP_PCT [4] = '{0, 46, 0, 26};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 46, 26};

    typedef logic [BYTE_W-1:0] byte_t;

    typedef enum logic [1:0] {ROW_FRAME, ROW_RAW, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_REPLY} row_chk_t;
    typedef enum logic [2:0] {
        FLAW_NONE, FLAW_BAD_N, FLAW_BAD_E, FLAW_BAD_R, FLAW_BAD_TOKEN, FLAW_BAD_CSUM
    } frame_flaw_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  cfg_idx;
        byte_t       len;     // frame length, or register value for ROW_CFG
        byte_t       cmd;     // command, or the lone byte for ROW_RAW
        frame_flaw_t flaw;
        byte_t       flaw_byte;
        row_chk_t    chk;
        byte_t       want_cmd;
        byte_t       want_status;
    } stim_row_t;

    typedef struct packed {
        byte_t data;
        logic  last;
    } reply_beat_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    byte_t      s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    byte_t      m_tdata;
    logic       m_tlast;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    byte_t      cfg_data;

    // parser copy and register copies, reset values
    parse_state_t prs_state = ST_WAIT_U;
    byte_t        prs_count = 8'h00;
    byte_t        prs_csum = 8'h00;
    byte_t        prs_cmd = 8'h00;
    logic         prs_first = 1'b0;
    byte_t        prs_alive = 8'd240;
    byte_t        prs_ack = 8'd13;
    byte_t        prs_unknown = 8'd255;

    reply_beat_t reply_bytes_due [$];
    byte_t       rx_bytes [$];
    stim_row_t   directed_rows [$];
    int          sender_gap_pct = 0;
    int          receiver_stall_pct = 0;
    int          error_count = 0;
    int          quiet_cycles = 0;

    framed_command_parser_responder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // one received byte through the parser; flags a reply when a good checksum lands
    task automatic advance_parser(input byte_t b, output logic reply_due);
        logic mismatch;
        mismatch  = 1'b0;
        reply_due = 1'b0;
        case (prs_state)
            ST_WAIT_U: if (b == CH_U) prs_state = ST_N;
            ST_N: if (b == CH_N) prs_state = ST_E; else mismatch = 1'b1;
            ST_E: if (b == CH_E) prs_state = ST_R; else mismatch = 1'b1;
            ST_R: if (b == CH_R) prs_state = ST_LEN; else mismatch = 1'b1;
            ST_LEN: begin
                prs_count = b;
                prs_state = ST_TOKEN;
            end
            ST_TOKEN: begin
                if (b == CH_COLON) begin
                    prs_csum  = HDR_XOR ^ prs_count;
                    prs_first = 1'b1;
                    prs_state = ST_PAYLOAD;
                end else begin
                    mismatch = 1'b1;
                end
            end
            ST_PAYLOAD: begin
                if (prs_first) begin
                    prs_cmd   = b;
                    prs_first = 1'b0;
                end
                prs_count = prs_count - 8'd1;
                if (prs_count != 8'd0) begin
                    prs_csum = prs_csum ^ b;
                end else begin
                    reply_due = (b == prs_csum);
                    prs_state = ST_WAIT_U;
                end
            end
            default: prs_state = ST_WAIT_U;
        endcase
        // a bad header or token byte gets a second look as a fresh 'U'
        if (mismatch) prs_state = (b == CH_U) ? ST_N : ST_WAIT_U;
    endtask

    function automatic void push_reply(input byte_t cmd, input byte_t status);
        byte_t body [8];
        byte_t x;
        x    = 8'h00;
        body = '{CH_U, CH_N, CH_E, CH_R, REPLY_LEN, CH_COLON, cmd, status};
        foreach (body[k]) begin
            x = x ^ body[k];
            reply_bytes_due.push_back('{data: body[k], last: 1'b0});
        end
        reply_bytes_due.push_back('{data: x, last: 1'b1});
    endfunction

    function automatic void build_frame(input byte_t len, input byte_t cmd,
                                        input frame_flaw_t flaw, input byte_t fb);
        byte_t csum;
        byte_t b;
        int    body_len;
        rx_bytes = '{CH_U, CH_N, CH_E, CH_R, len, CH_COLON};
        csum     = HDR_XOR ^ len;
        body_len = (len == 8'd0) ? 255 : int'(len) - 1;
        for (int k = 0; k < body_len; k++) begin
            b    = (k == 0) ? cmd : byte_t'($urandom_range(255));
            csum = csum ^ b;
            rx_bytes.push_back(b);
        end
        rx_bytes.push_back((flaw == FLAW_BAD_CSUM) ? (csum ^ fb) : csum);
        case (flaw)
            FLAW_BAD_N:     rx_bytes[RB_N] = fb;
            FLAW_BAD_E:     rx_bytes[RB_E] = fb;
            FLAW_BAD_R:     rx_bytes[RB_R] = fb;
            FLAW_BAD_TOKEN: rx_bytes[RB_COLON] = fb;
            default: ;
        endcase
    endfunction

    // fills rx_bytes with a good frame, a broken one or noise; noise is not counted
    function automatic int build_random_unit();
        int          roll;
        byte_t       len;
        byte_t       cmd;
        byte_t       fb;
        frame_flaw_t flaw;
        roll = $urandom_range(99);
        len  = ($urandom_range(9) == 0) ? byte_t'($urandom_range(24, 7))
                                        : byte_t'($urandom_range(6, 1));
        cmd  = ($urandom_range(1) == 0) ? prs_alive : byte_t'($urandom_range(255));
        fb   = ($urandom_range(3) == 0) ? CH_U : byte_t'($urandom_range(255));
        if (roll < 70) begin
            build_frame(len, cmd, FLAW_NONE, 8'h00);
        end else if (roll < 85) begin
            flaw = frame_flaw_t'($urandom_range(FLAW_BAD_CSUM, FLAW_BAD_N));
            build_frame(len, cmd, flaw, fb);
        end else begin
            rx_bytes.delete();
            repeat ($urandom_range(4, 1))
                rx_bytes.push_back(($urandom_range(3) == 0) ? CH_U : byte_t'($urandom_range(255)));
            return 0;
        end
        return rx_bytes.size();
    endfunction

    function automatic byte_t pick_reg_value();
        case ($urandom_range(3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return byte_t'($urandom_range(255));
        endcase
    endfunction

    function automatic stim_row_t frame_row(input byte_t len, input byte_t cmd,
            input frame_flaw_t flaw, input byte_t fb, input row_chk_t chk,
            input byte_t want_cmd = 8'h00, input byte_t want_status = 8'h00);
        return '{kind: ROW_FRAME, cfg_idx: 2'd0, len: len, cmd: cmd, flaw: flaw,
                 flaw_byte: fb, chk: chk, want_cmd: want_cmd, want_status: want_status};
    endfunction

    function automatic stim_row_t cfg_row(input logic [1:0] idx, input byte_t val);
        return '{kind: ROW_CFG, cfg_idx: idx, len: val, cmd: 8'h00, flaw: FLAW_NONE,
                 flaw_byte: 8'h00, chk: CHK_NONE, want_cmd: 8'h00, want_status: 8'h00};
    endfunction

    function automatic stim_row_t raw_row(input byte_t b);
        return '{kind: ROW_RAW, cfg_idx: 2'd0, len: 8'h00, cmd: b, flaw: FLAW_NONE,
                 flaw_byte: 8'h00, chk: CHK_MODEL, want_cmd: 8'h00, want_status: 8'h00};
    endfunction

    // called and returns at a falling edge; leaves s_tvalid high for the next item
    task automatic send_rx_bytes(input row_chk_t chk, input byte_t want_cmd,
                                 input byte_t want_status);
        logic due;
        for (int i = 0; i < rx_bytes.size(); i++) begin
            while ($urandom_range(99) < sender_gap_pct) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= rx_bytes[i];
            do @(posedge aclk); while (!s_tready);
            advance_parser(rx_bytes[i], due);
            if (chk == CHK_MODEL && due)
                push_reply(prs_cmd, (prs_cmd == prs_alive) ? prs_ack : prs_unknown);
            if (chk == CHK_REPLY && i == rx_bytes.size() - 1)
                push_reply(want_cmd, want_status);
            @(negedge aclk);
        end
    endtask

    task automatic drain_replies();
        s_tvalid <= 1'b0;
        while (reply_bytes_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input byte_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_ALIVE_CMD:    prs_alive = val;
            CFG_ACK_CODE:     prs_ack = val;
            CFG_UNKNOWN_CODE: prs_unknown = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    always @(posedge aclk) begin
        reply_beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (reply_bytes_due.size() == 0) begin
                $display("%0t: reply byte with nothing due: tx_byte %02h last_byte %0b",
                         $time, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = reply_bytes_due.pop_front();
                if (m_tdata !== want.data) begin
                    $display("%0t: tx_byte expected %02h actual %02h",
                             $time, want.data, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last_byte expected %0b actual %0b",
                             $time, want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d reply bytes still due",
                     $time, WATCHDOG_LIMIT, reply_bytes_due.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    initial begin
        int sent;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;

        // registers at reset values: alive 240, ack 13, unknown 255
        directed_rows.push_back(frame_row(8'd2, 8'd240, FLAW_NONE, 8'h00, CHK_REPLY, 8'd240, 8'd13));
        directed_rows.push_back(frame_row(8'd2, 8'd0, FLAW_NONE, 8'h00, CHK_REPLY, 8'd0, 8'd255));
        directed_rows.push_back(frame_row(8'd2, 8'd255, FLAW_NONE, 8'h00, CHK_REPLY, 8'd255, 8'd255));
        // length one: the checksum byte doubles as the command
        directed_rows.push_back(frame_row(8'd1, 8'd0, FLAW_NONE, 8'h00, CHK_REPLY, 8'h37, 8'd255));
        directed_rows.push_back(frame_row(8'd5, 8'd241, FLAW_NONE, 8'h00, CHK_MODEL));
        directed_rows.push_back(frame_row(8'd3, 8'd240, FLAW_BAD_N, 8'h00, CHK_NONE));
        directed_rows.push_back(frame_row(8'd3, 8'd240, FLAW_BAD_E, CH_U, CHK_NONE));
        directed_rows.push_back(frame_row(8'd3, 8'd240, FLAW_BAD_R, 8'hFF, CHK_NONE));
        directed_rows.push_back(frame_row(8'd3, 8'd240, FLAW_BAD_TOKEN, 8'h3B, CHK_NONE));
        directed_rows.push_back(frame_row(8'd3, 8'h10, FLAW_BAD_TOKEN, CH_U, CHK_NONE));
        directed_rows.push_back(frame_row(8'd3, 8'd240, FLAW_BAD_CSUM, 8'h80, CHK_NONE));
        directed_rows.push_back(frame_row(8'd2, 8'd240, FLAW_BAD_CSUM, 8'h01, CHK_NONE));
        // stray 'U' right before a header
        directed_rows.push_back(raw_row(CH_U));
        directed_rows.push_back(frame_row(8'd3, 8'd240, FLAW_NONE, 8'h00, CHK_REPLY, 8'd240, 8'd13));
        directed_rows.push_back(cfg_row(CFG_ALIVE_CMD, 8'h00));
        directed_rows.push_back(cfg_row(CFG_ACK_CODE, 8'h00));
        directed_rows.push_back(cfg_row(CFG_IDX_SPARE, 8'h5A));
        directed_rows.push_back(frame_row(8'd2, 8'd0, FLAW_NONE, 8'h00, CHK_REPLY, 8'd0, 8'd0));
        directed_rows.push_back(cfg_row(CFG_ACK_CODE, 8'hFF));
        directed_rows.push_back(cfg_row(CFG_UNKNOWN_CODE, 8'h00));
        directed_rows.push_back(frame_row(8'd2, 8'd1, FLAW_NONE, 8'h00, CHK_REPLY, 8'd1, 8'd0));
        directed_rows.push_back(cfg_row(CFG_ALIVE_CMD, 8'hFF));
        directed_rows.push_back(frame_row(8'd2, 8'd255, FLAW_NONE, 8'h00, CHK_REPLY, 8'd255, 8'd255));
        directed_rows.push_back(frame_row(8'd4, 8'd0, FLAW_NONE, 8'h00, CHK_MODEL));

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_CFG: begin
                    drain_replies();
                    write_reg(directed_rows[r].cfg_idx, directed_rows[r].len);
                end
                ROW_RAW: begin
                    rx_bytes = '{directed_rows[r].cmd};
                    send_rx_bytes(CHK_MODEL, 8'h00, 8'h00);
                end
                default: begin
                    build_frame(directed_rows[r].len, directed_rows[r].cmd,
                                directed_rows[r].flaw, directed_rows[r].flaw_byte);
                    send_rx_bytes(directed_rows[r].chk, directed_rows[r].want_cmd,
                                  directed_rows[r].want_status);
                end
            endcase
        end

        for (int ph = 0; ph < 4; ph++) begin
            drain_replies();
            sender_gap_pct     = SEND_GAP_PCT[ph];
            receiver_stall_pct = RECV_STALL_PCT[ph];
            if ($urandom_range(2) != 0) write_reg(CFG_ALIVE_CMD, pick_reg_value());
            if ($urandom_range(2) != 0) write_reg(CFG_ACK_CODE, pick_reg_value());
            if ($urandom_range(2) != 0) write_reg(CFG_UNKNOWN_CODE, pick_reg_value());
            if ($urandom_range(3) == 0) write_reg(CFG_IDX_SPARE, pick_reg_value());
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                sent += build_random_unit();
                send_rx_bytes(CHK_MODEL, 8'h00, 8'h00);
            end
        end

        drain_replies();
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
